### sv/fla_pkg.sv
// Shared constants, codes and types for the free-list allocator.
package fla_pkg;

    // Free-region table size
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = IDX_W + 1;

    // Stream word widths
    localparam int IN_W  = 72;
    localparam int OUT_W = 144;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOFIT = 2'd1;
    localparam logic [1:0] STAT_LOST  = 2'd2;

    // Datapath operation codes
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
    localparam logic [OP_W-1:0] OP_LATCH   = 4'd1;
    localparam logic [OP_W-1:0] OP_A_STEP  = 4'd2;
    localparam logic [OP_W-1:0] OP_A_TAKE  = 4'd3;
    localparam logic [OP_W-1:0] OP_A_NOFIT = 4'd4;
    localparam logic [OP_W-1:0] OP_F_STEP  = 4'd5;
    localparam logic [OP_W-1:0] OP_F_STOP  = 4'd6;
    localparam logic [OP_W-1:0] OP_F_MPREV = 4'd7;
    localparam logic [OP_W-1:0] OP_F_MNEXT = 4'd8;
    localparam logic [OP_W-1:0] OP_F_INS   = 4'd9;
    localparam logic [OP_W-1:0] OP_F_LOST  = 4'd10;
    localparam logic [OP_W-1:0] OP_MOVE_DN = 4'd11;
    localparam logic [OP_W-1:0] OP_MOVE_UP = 4'd12;
    localparam logic [OP_W-1:0] OP_RM_DONE = 4'd13;
    localparam logic [OP_W-1:0] OP_INS_DONE = 4'd14;

    // Controller to datapath
    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_free;   // latched request is a free
        logic scan_end;  // read pointer has reached the entry count
        logic a_hit;     // entry under check fits the request
        logic a_empty;   // that entry becomes empty
        logic f_gt;      // entry under check starts above the freed address
        logic mprev;     // freed region joins the entry before it
        logic mnext;     // freed region joins the entry after it
        logic full;      // table has no free slot
        logic mv_done;   // block move finished
    } sts_t;

endpackage

### sv/free_list_allocator.sv
// Top level of the first-fit free-list allocator.
// Input channel s_*: one word per request (action, addr, size). action 0
// allocates: the lowest-addressed region at least size bytes long is cut
// from its front and its start returned. action 1 frees: the region joins
// its neighbors where they touch, else gets a new sorted entry, else is
// counted as lost when all 64 entries are taken.
// Output channel m_*: one result word per request with the allocated
// address, status and the running totals.
// One request is handled at a time. It is taken and decoded, the table is
// scanned entry by entry through a registered read, and for a removal or
// insertion the tail of the table is moved entry by entry, all bound by the
// single read and write port of the region table.
// s_tready is high only while idle. A result is held on m_* until m_tready;
// no new request is taken meanwhile. Reset clears the counters and empties
// the table; no clearing pass is needed.
module free_list_allocator (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [fla_pkg::IN_W-1:0]  s_tdata,  // action, addr, size, zero pad
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [fla_pkg::OUT_W-1:0] m_tdata   // alloc_addr, status, free_total,
                                                // entry_count, peak_entries,
                                                // lost_count, lost_bytes
);

    fla_pkg::cmd_t cmd;
    fla_pkg::sts_t sts;

    fla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fla_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .sts     (sts),
        .m_tdata (m_tdata)
    );

endmodule

### sv/fla_datapath.sv
// Datapath of the free-list allocator: region table memory, pointers and counters.
module fla_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [fla_pkg::IN_W-1:0]  s_tdata,
    input  fla_pkg::cmd_t             cmd,
    output fla_pkg::sts_t             sts,
    output logic [fla_pkg::OUT_W-1:0] m_tdata
);

    // Region table: {start, length}
    logic [63:0] mem [fla_pkg::TABLE_ENTRIES];
    logic [63:0] rd_q;

    // Request latch
    logic        act_reg;
    logic [31:0] addr_reg;
    logic [31:0] size_reg;

    // Pointers
    logic [fla_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [fla_pkg::CNT_W-1:0] wa_reg, wa_next;
    logic [fla_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [fla_pkg::CNT_W-1:0] p_reg, p_next;
    logic                      pend_reg, pend_next;
    logic [63:0]               prev_reg, prev_next;
    logic [63:0]               cur_reg, cur_next;

    // Counters and results
    logic [fla_pkg::CNT_W-1:0] used_reg, used_next;
    logic [fla_pkg::CNT_W-1:0] peak_reg, peak_next;
    logic [31:0]               free_reg, free_next;
    logic [31:0]               lcnt_reg, lcnt_next;
    logic [31:0]               lbytes_reg, lbytes_next;
    logic [31:0]               raddr_reg, raddr_next;
    logic [1:0]                rstat_reg, rstat_next;

    // Memory write port
    logic                      we;
    logic [fla_pkg::CNT_W-1:0] wa;
    logic [63:0]               wd;

    logic [31:0] rd_start, rd_len;
    logic [31:0] prev_start, prev_len, cur_start, cur_len;
    logic [31:0] sum_len;

    assign rd_start   = rd_q[63:32];
    assign rd_len     = rd_q[31:0];
    assign prev_start = prev_reg[63:32];
    assign prev_len   = prev_reg[31:0];
    assign cur_start  = cur_reg[63:32];
    assign cur_len    = cur_reg[31:0];
    assign sum_len    = prev_len + size_reg + (sts.mnext ? cur_len : 32'd0);

    // Status toward the controller
    always_comb
    begin
        sts.is_free  = act_reg;
        sts.scan_end = (idx_reg >= used_reg);
        sts.a_hit    = pend_reg && (rd_len >= size_reg);
        sts.a_empty  = (rd_len == size_reg);
        sts.f_gt     = pend_reg && (rd_start > addr_reg);
        sts.mprev    = (p_reg != '0) && (prev_start + prev_len == addr_reg);
        sts.mnext    = (p_reg < used_reg) && (addr_reg + size_reg == cur_start);
        sts.full     = (used_reg == fla_pkg::CNT_W'(fla_pkg::TABLE_ENTRIES));
        sts.mv_done  = (cnt_reg == '0) && !pend_reg;
    end

    // Operation decode
    always_comb
    begin
        idx_next    = idx_reg;
        wa_next     = wa_reg;
        cnt_next    = cnt_reg;
        p_next      = p_reg;
        pend_next   = pend_reg;
        prev_next   = prev_reg;
        cur_next    = cur_reg;
        used_next   = used_reg;
        peak_next   = peak_reg;
        free_next   = free_reg;
        lcnt_next   = lcnt_reg;
        lbytes_next = lbytes_reg;
        raddr_next  = raddr_reg;
        rstat_next  = rstat_reg;
        we          = 1'b0;
        wa          = idx_reg;
        wd          = rd_q;
        unique case (cmd.op)
            fla_pkg::OP_LATCH:
            begin
                idx_next  = '0;
                pend_next = 1'b0;
            end
            fla_pkg::OP_A_STEP:
            begin
                idx_next  = idx_reg + 1'b1;
                pend_next = 1'b1;
            end
            fla_pkg::OP_A_TAKE:
            begin
                raddr_next = rd_start;
                rstat_next = fla_pkg::STAT_OK;
                free_next  = free_reg - size_reg;
                pend_next  = 1'b0;
                if (!sts.a_empty)
                begin
                    we = 1'b1;
                    wa = idx_reg - 1'b1;
                    wd = {rd_start + size_reg, rd_len - size_reg};
                end
                else
                begin
                    // remove entry idx-1: pull the tail down by one
                    wa_next  = idx_reg - 1'b1;
                    cnt_next = used_reg - idx_reg;
                end
            end
            fla_pkg::OP_A_NOFIT:
            begin
                raddr_next = '0;
                rstat_next = fla_pkg::STAT_NOFIT;
            end
            fla_pkg::OP_F_STEP:
            begin
                if (pend_reg)
                begin
                    prev_next = rd_q;
                end
                idx_next  = idx_reg + 1'b1;
                pend_next = 1'b1;
            end
            fla_pkg::OP_F_STOP:
            begin
                pend_next = 1'b0;
                if (sts.f_gt)
                begin
                    p_next   = idx_reg - 1'b1;
                    cur_next = rd_q;
                end
                else
                begin
                    p_next = idx_reg;
                    if (pend_reg)
                    begin
                        prev_next = rd_q;
                    end
                end
            end
            fla_pkg::OP_F_MPREV:
            begin
                we         = 1'b1;
                wa         = p_reg - 1'b1;
                wd         = {prev_start, sum_len};
                free_next  = free_reg + size_reg;
                raddr_next = '0;
                rstat_next = fla_pkg::STAT_OK;
                idx_next   = p_reg + 1'b1;
                wa_next    = p_reg;
                cnt_next   = used_reg - p_reg - 1'b1;
                pend_next  = 1'b0;
            end
            fla_pkg::OP_F_MNEXT:
            begin
                we         = 1'b1;
                wa         = p_reg;
                wd         = {addr_reg, cur_len + size_reg};
                free_next  = free_reg + size_reg;
                raddr_next = '0;
                rstat_next = fla_pkg::STAT_OK;
            end
            fla_pkg::OP_F_INS:
            begin
                raddr_next = '0;
                rstat_next = fla_pkg::STAT_OK;
                idx_next   = used_reg - 1'b1;
                wa_next    = used_reg;
                cnt_next   = used_reg - p_reg;
                pend_next  = 1'b0;
            end
            fla_pkg::OP_F_LOST:
            begin
                lcnt_next   = lcnt_reg + 1'b1;
                lbytes_next = lbytes_reg + size_reg;
                raddr_next  = '0;
                rstat_next  = fla_pkg::STAT_LOST;
            end
            fla_pkg::OP_MOVE_DN, fla_pkg::OP_MOVE_UP:
            begin
                // one read issued and one write retired per cycle
                if (pend_reg)
                begin
                    we      = 1'b1;
                    wa      = wa_reg;
                    wd      = rd_q;
                    wa_next = (cmd.op == fla_pkg::OP_MOVE_DN) ? wa_reg + 1'b1 : wa_reg - 1'b1;
                end
                if (cnt_reg != '0)
                begin
                    idx_next  = (cmd.op == fla_pkg::OP_MOVE_DN) ?
                                idx_reg + 1'b1 : idx_reg - 1'b1;
                    cnt_next  = cnt_reg - 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            fla_pkg::OP_RM_DONE:
            begin
                used_next = used_reg - 1'b1;
            end
            fla_pkg::OP_INS_DONE:
            begin
                we        = 1'b1;
                wa        = p_reg;
                wd        = {addr_reg, size_reg};
                used_next = used_reg + 1'b1;
                if (peak_reg < used_reg + 1'b1)
                begin
                    peak_next = used_reg + 1'b1;
                end
                free_next = free_reg + size_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Table memory, registered read at the scan pointer
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa[fla_pkg::IDX_W-1:0]] <= wd;
        end
        rd_q <= mem[idx_reg[fla_pkg::IDX_W-1:0]];
    end

    // Request latch and working payload
    always_ff @(posedge clk)
    begin
        if (cmd.op == fla_pkg::OP_LATCH)
        begin
            act_reg  <= s_tdata[0];
            addr_reg <= s_tdata[32:1];
            size_reg <= s_tdata[64:33];
        end
        wa_reg    <= wa_next;
        cnt_reg   <= cnt_next;
        p_reg     <= p_next;
        prev_reg  <= prev_next;
        cur_reg   <= cur_next;
        raddr_reg <= raddr_next;
        rstat_reg <= rstat_next;
    end

    // Control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            pend_reg   <= 1'b0;
            used_reg   <= '0;
            peak_reg   <= '0;
            free_reg   <= '0;
            lcnt_reg   <= '0;
            lbytes_reg <= '0;
        end
        else
        begin
            idx_reg    <= idx_next;
            pend_reg   <= pend_next;
            used_reg   <= used_next;
            peak_reg   <= peak_next;
            free_reg   <= free_next;
            lcnt_reg   <= lcnt_next;
            lbytes_reg <= lbytes_next;
        end
    end

    // Result word
    assign m_tdata = {lbytes_reg, lcnt_reg, 7'(peak_reg), 7'(used_reg),
                      free_reg, rstat_reg, raddr_reg};

    // Entry count moves by at most one per cycle
    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (used_reg == $past(used_reg) || used_reg == $past(used_reg) + 1'b1 ||
             used_reg == $past(used_reg) - 1'b1))
        else $error("entry count jumped");

    // Peak never falls and never trails the entry count
    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (peak_reg >= $past(peak_reg) && peak_reg >= used_reg))
        else $error("peak entry count wrong");

    // Table never overfills
    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == fla_pkg::OP_INS_DONE) |-> !sts.full)
        else $error("insert into full table");

endmodule

### sv/fla_ctrl.sv
// Controller state machine of the free-list allocator.
module fla_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  fla_pkg::sts_t sts,
    output fla_pkg::cmd_t cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DISP   = 4'd1;
    localparam logic [3:0] ST_A_SCAN = 4'd2;
    localparam logic [3:0] ST_F_SCAN = 4'd3;
    localparam logic [3:0] ST_F_DEC  = 4'd4;
    localparam logic [3:0] ST_MV_DN  = 4'd5;
    localparam logic [3:0] ST_MV_UP  = 4'd6;
    localparam logic [3:0] ST_OUT    = 4'd7;

    logic [3:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);

    // Next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = fla_pkg::OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = fla_pkg::OP_LATCH;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                state_next = sts.is_free ? ST_F_SCAN : ST_A_SCAN;
            end
            ST_A_SCAN:
            begin
                priority if (sts.a_hit)
                begin
                    cmd.op     = fla_pkg::OP_A_TAKE;
                    state_next = sts.a_empty ? ST_MV_DN : ST_OUT;
                end
                else if (sts.scan_end)
                begin
                    cmd.op     = fla_pkg::OP_A_NOFIT;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.op = fla_pkg::OP_A_STEP;
                end
            end
            ST_F_SCAN:
            begin
                if (sts.f_gt || sts.scan_end)
                begin
                    cmd.op     = fla_pkg::OP_F_STOP;
                    state_next = ST_F_DEC;
                end
                else
                begin
                    cmd.op = fla_pkg::OP_F_STEP;
                end
            end
            ST_F_DEC:
            begin
                priority if (sts.mprev)
                begin
                    cmd.op     = fla_pkg::OP_F_MPREV;
                    state_next = sts.mnext ? ST_MV_DN : ST_OUT;
                end
                else if (sts.mnext)
                begin
                    cmd.op     = fla_pkg::OP_F_MNEXT;
                    state_next = ST_OUT;
                end
                else if (!sts.full)
                begin
                    cmd.op     = fla_pkg::OP_F_INS;
                    state_next = ST_MV_UP;
                end
                else
                begin
                    cmd.op     = fla_pkg::OP_F_LOST;
                    state_next = ST_OUT;
                end
            end
            ST_MV_DN:
            begin
                if (sts.mv_done)
                begin
                    cmd.op     = fla_pkg::OP_RM_DONE;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.op = fla_pkg::OP_MOVE_DN;
                end
            end
            ST_MV_UP:
            begin
                if (sts.mv_done)
                begin
                    cmd.op     = fla_pkg::OP_INS_DONE;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.op = fla_pkg::OP_MOVE_UP;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // One request in flight: taking a word closes the input
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while busy");

    // Input and output sides are never open together
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input open while result pending");

    // A delivered result returns the block to idle
    a_back: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) |=> s_tready)
        else $error("no return to idle after result");

endmodule

### tb/free_list_allocator_checker.sv
// Checker for the free-list allocator: predicts each result word and compares it.
`timescale 1ns / 1ps

module free_list_allocator_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [fla_pkg::IN_W-1:0]  s_tdata,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [fla_pkg::OUT_W-1:0] m_tdata,
    output int                        errors,
    output int                        pending,
    output int                        checked,
    output int                        lost_seen
);

    typedef struct packed {
        logic [31:0] lost_bytes;
        logic [31:0] lost_count;
        logic [6:0]  peak_entries;
        logic [6:0]  entry_count;
        logic [31:0] free_total;
        logic [1:0]  status;
        logic [31:0] alloc_addr;
    } result_t;

    // model of the free table
    logic [31:0] reg_start [fla_pkg::TABLE_ENTRIES];
    logic [31:0] reg_len   [fla_pkg::TABLE_ENTRIES];
    int          used_cnt;
    int          peak_cnt;
    logic [31:0] drop_cnt;
    logic [31:0] drop_bytes;
    logic [31:0] bytes_free;

    result_t expected_results [$];

    function automatic void drop_entry(int idx);
        for (int k = idx; k + 1 < used_cnt; k++)
        begin
            reg_start[k] = reg_start[k + 1];
            reg_len[k]   = reg_len[k + 1];
        end
        used_cnt--;
    endfunction

    function automatic result_t allocator_step(logic act, logic [31:0] addr, logic [31:0] size);
        result_t     r;
        int          p;
        bit          hit;
        logic [31:0] stop;
        r = '0;
        hit = 0;
        stop = addr + size;
        if (act == 1'b0)
        begin
            // first fit from the lowest address
            for (int i = 0; i < used_cnt && !hit; i++)
            begin
                if (reg_len[i] >= size)
                begin
                    hit = 1;
                    r.alloc_addr = reg_start[i];
                    reg_start[i] += size;
                    reg_len[i]   -= size;
                    bytes_free   -= size;
                    if (reg_len[i] == 0)
                        drop_entry(i);
                end
            end
            r.status = hit ? fla_pkg::STAT_OK : fla_pkg::STAT_NOFIT;
        end
        else
        begin
            p = 0;
            while (p < used_cnt && reg_start[p] <= addr)
                p++;
            r.status = fla_pkg::STAT_OK;
            if (p > 0 && reg_start[p - 1] + reg_len[p - 1] == addr)
            begin
                // joins the region below, maybe the one above too
                reg_len[p - 1] += size;
                bytes_free     += size;
                if (p < used_cnt && stop == reg_start[p])
                begin
                    reg_len[p - 1] += reg_len[p];
                    drop_entry(p);
                end
            end
            else if (p < used_cnt && stop == reg_start[p])
            begin
                reg_start[p] = addr;
                reg_len[p]  += size;
                bytes_free  += size;
            end
            else if (used_cnt < fla_pkg::TABLE_ENTRIES)
            begin
                for (int j = used_cnt; j > p; j--)
                begin
                    reg_start[j] = reg_start[j - 1];
                    reg_len[j]   = reg_len[j - 1];
                end
                used_cnt++;
                if (peak_cnt < used_cnt)
                    peak_cnt = used_cnt;
                reg_start[p] = addr;
                reg_len[p]   = size;
                bytes_free  += size;
            end
            else
            begin
                drop_cnt++;
                drop_bytes += size;
                r.status = fla_pkg::STAT_LOST;
            end
        end
        r.free_total   = bytes_free;
        r.entry_count  = used_cnt[6:0];
        r.peak_entries = peak_cnt[6:0];
        r.lost_count   = drop_cnt;
        r.lost_bytes   = drop_bytes;
        return r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            used_cnt   = 0;
            peak_cnt   = 0;
            drop_cnt   = '0;
            drop_bytes = '0;
            bytes_free = '0;
            errors     <= 0;
            checked    <= 0;
            lost_seen  <= 0;
            expected_results.delete();
        end
        else
        begin
            // result word out
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected word %h", $time, got);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    checked <= checked + 1;
                    if (got.status == fla_pkg::STAT_LOST)
                        lost_seen <= lost_seen + 1;
                    if (got !== want)
                    begin
                        errors <= errors + 1;
                        if (got.alloc_addr !== want.alloc_addr)
                            $display("%0t: alloc_addr exp %h got %h", $time,
                                     want.alloc_addr, got.alloc_addr);
                        if (got.status !== want.status)
                            $display("%0t: status exp %0d got %0d", $time,
                                     want.status, got.status);
                        if (got.free_total !== want.free_total)
                            $display("%0t: free_total exp %h got %h", $time,
                                     want.free_total, got.free_total);
                        if (got.entry_count !== want.entry_count)
                            $display("%0t: entry_count exp %0d got %0d", $time,
                                     want.entry_count, got.entry_count);
                        if (got.peak_entries !== want.peak_entries)
                            $display("%0t: peak_entries exp %0d got %0d", $time,
                                     want.peak_entries, got.peak_entries);
                        if (got.lost_count !== want.lost_count)
                            $display("%0t: lost_count exp %h got %h", $time,
                                     want.lost_count, got.lost_count);
                        if (got.lost_bytes !== want.lost_bytes)
                            $display("%0t: lost_bytes exp %h got %h", $time,
                                     want.lost_bytes, got.lost_bytes);
                    end
                end
            end
            // request word in
            if (s_tvalid && s_tready)
                expected_results.push_back(allocator_step(s_tdata[0], s_tdata[32:1],
                                                          s_tdata[64:33]));
        end
    end

endmodule

### tb/tb.sv
// Testbench top for the free-list allocator: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [fla_pkg::IN_W-1:0]  s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [fla_pkg::OUT_W-1:0] m_tdata;
    int                        errors;
    int                        pending;
    int                        checked;
    int                        lost_seen;
    bit                        no_idle;

    free_list_allocator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // action, addr, size, zero pad
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // alloc_addr, status, free_total, entry_count,
                               // peak_entries, lost_count, lost_bytes
    );

    free_list_allocator_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked),
        .lost_seen (lost_seen)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver stalls
    always @(negedge clk)
        m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 30);

    // one request word; waits out a random gap first
    task automatic send_word(logic act, logic [31:0] addr, logic [31:0] size);
        while (!no_idle && $urandom_range(0, 99) < 30)
            @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = {7'd0, size, addr, act};
        while (!s_tready)
            @(negedge clk);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // mostly block-aligned regions so frees merge and allocs split
    task automatic send_random();
        logic [31:0] addr;
        logic [31:0] size;
        addr = $urandom_range(0, 127) * 256 + $urandom_range(0, 3) * 64;
        size = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 256) : 32'd64;
        if ($urandom_range(0, 19) == 0)
        begin
            addr = $urandom;
            size = $urandom;
        end
        if ($urandom_range(0, 1) == 0)
            send_word(ACT_ALLOC, '0, ($urandom_range(0, 19) == 0) ? $urandom
                                                                  : $urandom_range(0, 300));
        else
            send_word(ACT_FREE, addr, size);
    endtask

    // run limit
    initial
    begin
        #8_000_000;
        $display("free_list_allocator: mismatch");
        $finish;
    end

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        no_idle  = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, merges, zero sizes, wrap, extremes
        send_word(ACT_ALLOC, 32'hFFFF_FFFF, 32'd4);
        send_word(ACT_ALLOC, '0, '0);
        send_word(ACT_FREE, 32'h100, 32'h100);
        send_word(ACT_FREE, 32'h300, 32'h100);
        send_word(ACT_FREE, 32'h200, 32'h100);
        send_word(ACT_ALLOC, '0, '0);
        send_word(ACT_ALLOC, '0, 32'h50);
        send_word(ACT_ALLOC, '0, 32'h1000);
        send_word(ACT_FREE, 32'h0, 32'h0);
        send_word(ACT_ALLOC, '0, '0);
        send_word(ACT_FREE, 32'h80, 32'hD0);
        send_word(ACT_FREE, 32'hFFFF_FFF0, 32'h20);
        send_word(ACT_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(ACT_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(ACT_ALLOC, '0, 32'h0FFF_FFF0);

        // fill the table, then drop frees
        for (int i = 0; i < fla_pkg::TABLE_ENTRIES + 2; i++)
            send_word(ACT_FREE, 32'h4000_0000 + i * 32'h10000, 32'd8);
        send_word(ACT_FREE, 32'h7000_0000, 32'hFFFF_FFFF);
        send_word(ACT_FREE, 32'h4000_0008, 32'd8);
        for (int i = 0; i < fla_pkg::TABLE_ENTRIES + 4; i++)
            send_word(ACT_ALLOC, '0, 32'd8);

        // random traffic with one long stretch at full rate
        for (int n = 0; n < 1050; n++)
        begin
            no_idle = (n >= 500 && n < 700);
            send_random();
        end
        no_idle = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);

        $display("checked %0d result words, %0d of them dropped frees", checked, lost_seen);
        if (errors == 0)
            $display("free_list_allocator: match");
        else
            $display("free_list_allocator: mismatch");
        $finish;
    end

endmodule
